### src/cdq_pkg.sv
package cdq_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CMD_W  = 3;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd4;

  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  // one-hot (or all-zero) strobes to every cell, already qualified by accept and not-rejected
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } cdq_ctrl_t;

endpackage

### src/cdq_cell.sv
// One position of the deque. Chain A holds elements front-first, chain B
// rear-first, so each end sits in cell 0 of one chain. Valid bits form a
// thermometer shared by both chains.
module cdq_cell
  import cdq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cdq_ctrl_t                ctrl,
  input  logic signed [WORD_W-1:0] value,
  input  logic signed [WORD_W-1:0] prev_a,
  input  logic signed [WORD_W-1:0] prev_b,
  input  logic                     prev_valid,
  input  logic signed [WORD_W-1:0] next_a,
  input  logic signed [WORD_W-1:0] next_b,
  input  logic                     next_valid,
  output logic signed [WORD_W-1:0] a,
  output logic signed [WORD_W-1:0] b,
  output logic                     valid
);

  logic append;

  // first free cell in the chain takes an appended word
  assign append = prev_valid && !valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.push_front || ctrl.push_rear) begin
      valid <= valid | prev_valid;
    end else if (ctrl.pop_front || ctrl.pop_rear) begin
      valid <= valid & next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push_front) begin
      a <= prev_a;
      if (append) begin
        b <= value;
      end
    end else if (ctrl.push_rear) begin
      b <= prev_b;
      if (append) begin
        a <= value;
      end
    end else if (ctrl.pop_front) begin
      a <= next_a;
    end else if (ctrl.pop_rear) begin
      b <= next_b;
    end
  end

endmodule

### src/circular_deque.sv
// channel  | handshake            | words
// ---------+----------------------+-----------------------------------------------
// command  | cmd_valid, cmd_stall | command, value
// result   | res_valid, res_stall | front_value, rear_value, is_empty, is_full,
//          |                      | rejected
//
// One word per cycle while the result side does not stall; each result appears in the cycle after its command is taken.
// Every cell of the chain updates in the same cycle, so DEPTH does not change the rate.
// The result is held in an output register; a new command is taken in the cycle
// that register empties, so a stalled result stalls the command side.
// Synchronous reset empties the queue; no clearing pass.
module circular_deque
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_stall,
  input  logic [CMD_W-1:0]         command,
  input  logic signed [WORD_W-1:0] value,
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic signed [WORD_W-1:0] front_value,
  output logic signed [WORD_W-1:0] rear_value,
  output logic                     is_empty,
  output logic                     is_full,
  output logic                     rejected
);

  logic signed [WORD_W-1:0] a_q [DEPTH];
  logic signed [WORD_W-1:0] b_q [DEPTH];
  logic [DEPTH-1:0]         valid_q;
  logic                     accept;
  logic                     is_push;
  logic                     is_pop;
  logic                     rej_next;
  cdq_ctrl_t                ctrl;

  assign cmd_stall = res_valid && res_stall;
  assign accept    = cmd_valid && !cmd_stall;

  assign is_empty = !valid_q[0];
  assign is_full  = valid_q[DEPTH-1];

  always_comb begin
    is_push = 1'b0;
    is_pop  = 1'b0;
    unique case (command)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: is_push = 1'b1;
      CMD_POP_FRONT, CMD_POP_REAR:   is_pop  = 1'b1;
      default: ;  // peek and unused codes
    endcase
  end

  assign rej_next = (is_push && is_full) || (is_pop && is_empty);

  always_comb begin
    ctrl = '0;
    if (accept && !rej_next) begin
      ctrl.push_front = (command == CMD_PUSH_FRONT);
      ctrl.push_rear  = (command == CMD_PUSH_REAR);
      ctrl.pop_front  = (command == CMD_POP_FRONT);
      ctrl.pop_rear   = (command == CMD_POP_REAR);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] prev_a;
    logic signed [WORD_W-1:0] prev_b;
    logic                     prev_valid;
    logic signed [WORD_W-1:0] next_a;
    logic signed [WORD_W-1:0] next_b;
    logic                     next_valid;

    if (i == 0) begin : g_first
      assign prev_a     = value;
      assign prev_b     = value;
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_a     = a_q[i-1];
      assign prev_b     = b_q[i-1];
      assign prev_valid = valid_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_a     = a_q[i];
      assign next_b     = b_q[i];
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_a     = a_q[i+1];
      assign next_b     = b_q[i+1];
      assign next_valid = valid_q[i+1];
    end

    cdq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .value      (value),
      .prev_a     (prev_a),
      .prev_b     (prev_b),
      .prev_valid (prev_valid),
      .next_a     (next_a),
      .next_b     (next_b),
      .next_valid (next_valid),
      .a          (a_q[i]),
      .b          (b_q[i]),
      .valid      (valid_q[i])
    );
  end

  // state only moves on accept, so the ends read straight off cell 0
  assign front_value = valid_q[0] ? a_q[0] : EMPTY_WORD;
  assign rear_value  = valid_q[0] ? b_q[0] : EMPTY_WORD;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      rejected  <= 1'b0;
    end else begin
      if (accept) begin
        res_valid <= 1'b1;
        rejected  <= rej_next;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_thermo : assert property (@(posedge clk) disable iff (rst)
    (valid_q & ~{valid_q[DEPTH-2:0], 1'b1}) == '0)
    else $error("occupancy not contiguous from the front");

  a_push_fills : assert property (@(posedge clk) disable iff (rst)
    accept && is_push |=> !is_empty && res_valid)
    else $error("push left the queue empty");

  a_full_reject : assert property (@(posedge clk) disable iff (rst)
    accept && is_push && is_full |=> is_full && rejected)
    else $error("push into full queue not rejected");

  a_pop_shrinks : assert property (@(posedge clk) disable iff (rst)
    accept && is_pop && !is_empty |=> !is_full && !rejected)
    else $error("pop did not free a slot");

endmodule
